// ===== hw/rtl/per_channel_min_spacing_limiter_assert.svh =====
// Assertion macros for the per-channel minimum spacing limiter.
// Included by the top level; no other dependencies.
// Both forms compile to nothing when SYNTHESIS is defined.
`ifndef PER_CHANNEL_MIN_SPACING_LIMITER_ASSERT_SVH
`define PER_CHANNEL_MIN_SPACING_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCMSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcmsl assertion failed");
// next-cycle implication
`define PCMSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcmsl assertion failed");
`else
`define PCMSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PCMSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/pcmsl_pkg.sv =====
// Shared types and constants for the per-channel minimum spacing limiter.
// No dependencies.
package pcmsl_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned CNT_W  = 32;

    localparam logic [CNT_W-1:0] MIN_SPACING_RST = 32'd500000;

    // one table entry per channel
    typedef struct packed {
        logic [TIME_W-1:0] last_time;
        logic [CNT_W-1:0]  honored;
        logic [CNT_W-1:0]  dropped;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ===== hw/rtl/pcmsl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pcmsl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port; holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pcmsl_calc.sv =====
// Spacing check and counter update for one channel entry.
// Depends on pcmsl_pkg.
module pcmsl_calc (
    input  pcmsl_pkg::t_entry                i_old,
    input  logic [pcmsl_pkg::TIME_W-1:0]     i_now_us,
    input  logic [pcmsl_pkg::CNT_W-1:0]      i_min_spacing_us,
    output pcmsl_pkg::t_entry                o_new,
    output logic                             o_allowed
);
    import pcmsl_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic              drop;

    // wrapping difference against the last honored time
    assign elapsed = i_now_us - i_old.last_time;
    assign drop    = (i_old.last_time != '0)
                  && (elapsed < {{(TIME_W-CNT_W){1'b0}}, i_min_spacing_us});

    always_comb begin
        o_new     = i_old;
        o_allowed = !drop;
        if (drop) begin
            o_new.dropped = i_old.dropped + 1'b1;
        end else begin
            o_new.last_time = i_now_us;
            o_new.honored   = i_old.honored + 1'b1;
        end
    end

endmodule

// ===== hw/rtl/per_channel_min_spacing_limiter.sv =====
// Per-channel minimum spacing limiter: channel table in a RAM, read-modify-write.
// Each accepted word reads its entry from the RAM into stage 1; its result is then
// written to the output register. Input stalls only while a word waits in stage 1
// behind a full, stalled output register.
// Throughput: 1 word per cycle while the output register is not stalled; a one-deep
// write-back forward covers the RAM read-during-write on back-to-back words of the
// same channel. Reset: synchronous; per-entry valid flops clear the whole table,
// an unwritten entry reads as zero. Spacing register resets to 500000.
`include "per_channel_min_spacing_limiter_assert.svh"

module per_channel_min_spacing_limiter #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pcmsl_pkg::CH_W-1:0]    i_channel,
    input  logic [pcmsl_pkg::TIME_W-1:0]  i_now_us,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_allowed,
    output logic [pcmsl_pkg::CNT_W-1:0]   o_honored_count,
    output logic [pcmsl_pkg::CNT_W-1:0]   o_dropped_count,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcmsl_pkg::CNT_W-1:0]   i_cfg_min_spacing_us
);
    import pcmsl_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // config register
    logic [CNT_W-1:0] r_min_spacing;

    // stage 1 (RAM read in flight)
    logic              r_s1_vld;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s1_in_range;
    logic              r_s1_hit;
    logic [TIME_W-1:0] r_s1_now;

    // table valid bits and write-back forward
    logic [CHANNELS-1:0] r_tbl_vld;
    logic                r_fwd_vld;
    logic [IDX_W-1:0]    r_fwd_idx;
    t_entry              r_fwd_entry;

    // output register
    logic             r_out_vld;
    logic             r_out_allowed;
    logic [CNT_W-1:0] r_out_honored;
    logic [CNT_W-1:0] r_out_dropped;

    logic             in_accept;
    logic             out_free;
    logic             s1_adv;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    logic             ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry           old_entry;
    t_entry           new_entry;
    logic             calc_allowed;

    // handshake
    assign out_free  = !r_out_vld || !i_stall;
    assign s1_adv    = r_s1_vld && out_free;
    assign o_stall   = r_s1_vld && !out_free;
    assign in_accept = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign in_range = ({{(32-CH_W){1'b0}}, i_channel} < 32'(CHANNELS));
    assign in_idx   = i_channel[IDX_W-1:0];
    assign ram_we   = s1_adv && r_s1_in_range;

    // table storage
    pcmsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_idx),
        .i_wdata (new_entry),
        .i_re    (in_accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // the forward register always holds the newest write, so a match is current
    always_comb begin
        priority if (r_fwd_vld && (r_fwd_idx == r_s1_idx)) begin
            old_entry = r_fwd_entry;
        end else if (r_s1_hit) begin
            old_entry = t_entry'(ram_rdata);
        end else begin
            old_entry = '0;
        end
    end

    pcmsl_calc u_calc (
        .i_old            (old_entry),
        .i_now_us         (r_s1_now),
        .i_min_spacing_us (r_min_spacing),
        .o_new            (new_entry),
        .o_allowed        (calc_allowed)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_spacing <= MIN_SPACING_RST;
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_tbl_vld     <= '0;
            r_fwd_vld     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_spacing <= i_cfg_min_spacing_us;
            end
            if (in_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (ram_we) begin
                r_tbl_vld[r_s1_idx] <= 1'b1;
                r_fwd_vld           <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx      <= in_idx;
            r_s1_in_range <= in_range;
            r_s1_hit      <= r_tbl_vld[in_idx];
            r_s1_now      <= i_now_us;
        end
        if (ram_we) begin
            r_fwd_idx   <= r_s1_idx;
            r_fwd_entry <= new_entry;
        end
        if (s1_adv) begin
            r_out_allowed <= r_s1_in_range ? calc_allowed : 1'b1;
            r_out_honored <= r_s1_in_range ? new_entry.honored : '0;
            r_out_dropped <= r_s1_in_range ? new_entry.dropped : '0;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_allowed       = r_out_allowed;
    assign o_honored_count = r_out_honored;
    assign o_dropped_count = r_out_dropped;

    // checks
    `PCMSL_ASSERT_IMP(a_we_only_on_adv, i_clk, i_rst_n, ram_we, s1_adv && r_s1_in_range)
    `PCMSL_ASSERT_NXT(a_s1_holds, i_clk, i_rst_n, r_s1_vld && !s1_adv, r_s1_vld && $stable(r_s1_idx))
    `PCMSL_ASSERT_NXT(a_accept_loads_s1, i_clk, i_rst_n, in_accept, r_s1_vld)

endmodule

// ===== tb/pcmsl_checker.sv =====
// Checker for the per-channel minimum spacing limiter: watches the request,
// result and configuration channels, predicts each result and compares it.
// Depends on pcmsl_pkg for the field widths and the spacing reset value.
module pcmsl_checker #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic [pcmsl_pkg::CH_W-1:0]    i_req_channel,
    input  logic [pcmsl_pkg::TIME_W-1:0]  i_req_now_us,
    // result channel
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic                          i_res_allowed,
    input  logic [pcmsl_pkg::CNT_W-1:0]   i_res_honored_count,
    input  logic [pcmsl_pkg::CNT_W-1:0]   i_res_dropped_count,
    // configuration channel
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [pcmsl_pkg::CNT_W-1:0]   i_cfg_min_spacing_us,
    // status for the testbench top
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_results,
    output int                            o_drops
);
    import pcmsl_pkg::*;

    typedef struct packed {
        logic             allowed;
        logic [CNT_W-1:0] honored;
        logic [CNT_W-1:0] dropped;
    } t_decision;

    // predicted limiter state
    logic [CNT_W-1:0]  spacing_us;
    logic [TIME_W-1:0] last_honored_us [CHANNELS];
    logic [CNT_W-1:0]  honored_total [CHANNELS];
    logic [CNT_W-1:0]  dropped_total [CHANNELS];

    t_decision decisions_due[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        drops_seen   = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_results    = 0;
        o_drops      = 0;
    end

    // Decide one request and update the channel's entry.
    function automatic t_decision decide(input logic [CH_W-1:0] ch,
                                         input logic [TIME_W-1:0] now);
        t_decision         d;
        logic [TIME_W-1:0] gap;
        logic              too_soon;
        d         = '0;
        d.allowed = 1'b1;
        // out-of-range channels always pass and report zero counts
        if (ch >= CHANNELS)
            return d;
        gap      = now - last_honored_us[ch];
        too_soon = (last_honored_us[ch] != '0) && (gap < {32'b0, spacing_us});
        if (too_soon) begin
            dropped_total[ch] = dropped_total[ch] + 1'b1;
        end else begin
            last_honored_us[ch] = now;
            honored_total[ch]   = honored_total[ch] + 1'b1;
        end
        d.allowed = !too_soon;
        d.honored = honored_total[ch];
        d.dropped = dropped_total[ch];
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_decision want;
        t_decision got;
        if (!i_rst_n) begin
            spacing_us = MIN_SPACING_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                last_honored_us[c] = '0;
                honored_total[c]   = '0;
                dropped_total[c]   = '0;
            end
            decisions_due.delete();
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready)
                spacing_us = i_cfg_min_spacing_us;

            // accepted request word
            if (i_req_valid && !i_req_stall)
                decisions_due.push_back(decide(i_req_channel, i_req_now_us));

            // accepted result word
            if (i_res_valid && !i_res_stall) begin
                results_seen++;
                got.allowed = i_res_allowed;
                got.honored = i_res_honored_count;
                got.dropped = i_res_dropped_count;
                if (!i_res_allowed)
                    drops_seen++;
                if (decisions_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d with nothing pending: allowed=%0b honored=%0d dropped=%0d",
                                 results_seen, got.allowed, got.honored, got.dropped);
                end else begin
                    want = decisions_due.pop_front();
                    if (got.allowed !== want.allowed || got.honored !== want.honored ||
                        got.dropped !== want.dropped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp allowed=%0b honored=%0d dropped=%0d, got allowed=%0b honored=%0d dropped=%0d",
                                     results_seen, want.allowed, want.honored, want.dropped,
                                     got.allowed, got.honored, got.dropped);
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= decisions_due.size();
        o_results    <= results_seen;
        o_drops      <= drops_seen;
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the per-channel minimum spacing limiter: drives requests,
// result stalls and spacing writes, and reports the verdict.
// Depends on pcmsl_pkg, per_channel_min_spacing_limiter and pcmsl_checker.
module testbench;
    import pcmsl_pkg::*;

    localparam int unsigned CHANNELS    = 8;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 216;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 400000;

    // spacing per random phase: includes both extremes
    localparam logic [CNT_W-1:0] PHASE_SPACING [PHASES] = '{
        32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd500000, 32'd37, 32'd65536, 32'd3
    };

    typedef enum logic [1:0] {
        FLOW_FULL,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } t_flow;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CH_W-1:0]   i_channel;
    logic [TIME_W-1:0] i_now_us;
    logic              o_valid;
    logic              i_stall;
    logic              o_allowed;
    logic [CNT_W-1:0]  o_honored_count;
    logic [CNT_W-1:0]  o_dropped_count;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_min_spacing_us;

    int    mismatch_count;
    int    pending;
    int    results_seen;
    int    drops_seen;
    int    requests_sent = 0;
    int    cycle_count   = 0;
    int    holds_asked   = 0;
    int    holds_done    = 0;
    int    hold_left     = 0;
    t_flow flow          = FLOW_FULL;

    // per-channel time of the last request sent, to build spaced sequences
    logic [TIME_W-1:0] sent_time [CHANNELS];

    per_channel_min_spacing_limiter #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_channel            (i_channel),
        .i_now_us             (i_now_us),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_allowed            (o_allowed),
        .o_honored_count      (o_honored_count),
        .o_dropped_count      (o_dropped_count),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_min_spacing_us (i_cfg_min_spacing_us)
    );

    pcmsl_checker #(
        .CHANNELS(CHANNELS)
    ) checker_i (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_req_valid          (i_valid),
        .i_req_stall          (o_stall),
        .i_req_channel        (i_channel),
        .i_req_now_us         (i_now_us),
        .i_res_valid          (o_valid),
        .i_res_stall          (i_stall),
        .i_res_allowed        (o_allowed),
        .i_res_honored_count  (o_honored_count),
        .i_res_dropped_count  (o_dropped_count),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_min_spacing_us (i_cfg_min_spacing_us),
        .o_mismatches         (mismatch_count),
        .o_pending            (pending),
        .o_results            (results_seen),
        .o_drops              (drops_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls per flow, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else begin
            case (flow)
                FLOW_SINK_STALLS: i_stall <= ($urandom_range(0, 99) < 69);
                FLOW_BOTH:        i_stall <= ($urandom_range(0, 99) < 10);
                default:          i_stall <= 1'b0;
            endcase
        end
    end

    // Offer one request word and wait until it is taken.
    task automatic send_request(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] now);
        int gap_pct;
        gap_pct = (flow == FLOW_SRC_GAPS) ? 69 : (flow == FLOW_BOTH) ? 10 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_channel <= ch;
        i_now_us  <= now;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    // Stop sending and wait for every pending result, plus pipeline slack.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_spacing(input logic [CNT_W-1:0] value);
        i_cfg_valid          <= 1'b1;
        i_cfg_min_spacing_us <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] span;
        int                pick;

        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_channel            = '0;
        i_now_us             = '0;
        i_stall              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_min_spacing_us = '0;
        for (int c = 0; c < CHANNELS; c++)
            sent_time[c] = {24'b0, 8'($urandom_range(1, 255)), $urandom};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset spacing of 500000, back to back
        send_request(8'd0, 64'd0);                     // honored at time zero
        send_request(8'd0, 64'd1);                     // zero still reads as none yet
        send_request(8'd0, 64'd100);                   // too soon
        send_request(8'd0, 64'd500000);                // one short of spacing
        send_request(8'd0, 64'd500001);                // exactly the spacing
        send_request(8'd0, 64'd5);                     // time going backwards
        send_request(8'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(8'd7, 64'd0);                     // wrap, gap of one
        send_request(8'd7, 64'd499999);                // wrap, gap equals spacing
        send_request(8'd8, 64'd123);                   // first out-of-range channel
        send_request(8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(8'd128, 64'd0);
        send_request(8'd3, 64'h8000_0000_0000_0000);
        send_request(8'd3, 64'h8000_0000_0000_0000);   // zero gap
        send_request(8'd3, 64'h8000_0000_0007_A120);   // exactly the spacing later
        send_request(8'd1, 64'h0000_0000_DEAD_BEEF);
        send_request(8'd2, 64'h5555_5555_5555_5555);
        send_request(8'd4, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(8'd5, 64'd1);
        send_request(8'd5, 64'd2);
        send_request(8'd6, 64'd500001);
        send_request(8'd6, 64'd1000000);
        send_request(8'd6, 64'd1000001);
        drain_results();

        // random phases, each with its own spacing and flow
        for (int p = 0; p < PHASES; p++) begin
            flow <= t_flow'(p % 4);
            drain_results();
            write_spacing(PHASE_SPACING[p]);
            span = {32'b0, PHASE_SPACING[p]};
            if (p == 2 || p == 5)
                holds_asked <= holds_asked + 1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                ch   = 8'($urandom_range(0, CHANNELS - 1));
                if (pick < 7) begin
                    // out-of-range channel, any time
                    ch  = 8'($urandom_range(CHANNELS, 255));
                    now = {$urandom, $urandom};
                end else if (pick < 12) begin
                    now = {$urandom, $urandom};
                end else if (pick < 14) begin
                    now = '0;
                end else if (pick < 17) begin
                    now = sent_time[ch] - 64'($urandom_range(1, 1000));
                end else begin
                    // spaced sequence: gaps around and across the spacing
                    case ($urandom_range(0, 3))
                        0:       delta = 64'($urandom_range(0, 3));
                        1:       delta = span + 64'($urandom_range(0, 4)) - 64'd2;
                        2:       delta = {$urandom, $urandom} % (span * 2 + 64'd1);
                        default: delta = span * 2 + 64'($urandom_range(0, 1000));
                    endcase
                    now = sent_time[ch] + delta;
                end
                if (ch < CHANNELS)
                    sent_time[ch] = now;
                send_request(ch, now);
            end
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests over %0d spacing settings and four flow patterns;",
                 requests_sent, PHASES + 1);
        $display("checked %0d results, %0d of them dropped for spacing.",
                 results_seen, drops_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pcmsl_pkg.sv
hw/rtl/pcmsl_ram.sv
hw/rtl/pcmsl_calc.sv
hw/rtl/per_channel_min_spacing_limiter.sv
tb/pcmsl_checker.sv
tb/testbench.sv
